// ----- hw/rtl/mer_pkg.sv -----
// Shared widths, codes and handshake types of the midpoint ellipse rasterizer.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mer_pkg;

  // Coordinate width, the widths that follow from it, and the index widths
  localparam int COORD_BITS    = 10;
  localparam int RAD_BITS      = COORD_BITS - 1;
  localparam int PIX_BITS      = COORD_BITS + 2;
  localparam int STEP_BITS     = 3 * COORD_BITS + 2;
  localparam int DEC_BITS      = 4 * COORD_BITS + 8;
  localparam int SQ_BITS       = 2 * RAD_BITS;
  localparam int T_BITS        = COORD_BITS + 1;
  localparam int MUL_W         = 2 * T_BITS;
  localparam int PROD_BITS     = 2 * MUL_W;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = COORD_BITS;
  localparam int EMIT_BITS     = 2;

  typedef logic [EMIT_BITS-1:0] emit_idx_t;
  localparam emit_idx_t EMIT_LAST = '1;

  // Configuration register indexes
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CENTER_X = 2'd0;
  localparam cfg_idx_t CFG_CENTER_Y = 2'd1;
  localparam cfg_idx_t CFG_RADIUS_X = 2'd2;
  localparam cfg_idx_t CFG_RADIUS_Y = 2'd3;

  // Where the arc stands
  typedef enum logic [1:0] {
    REG_IDLE,
    REG_ONE,
    REG_TWO,
    REG_FIN
  } region_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_B,
    ST_SQ_C,
    ST_LOAD,
    ST_DONE,
    ST_SW_T,
    ST_SW_BT,
    ST_SW_U,
    ST_SW_AU,
    ST_SW_AB,
    ST_SW_FIN,
    ST_EMIT,
    ST_R1_UX,
    ST_R1_UY,
    ST_R2_DEC
  } state_e;

  // Operand pairs for the shared multiplier
  typedef enum logic [3:0] {
    MUL_RX_SQ,
    MUL_RY_SQ,
    MUL_A2_RY,
    MUL_T_SQ,
    MUL_B2_P,
    MUL_U_SQ,
    MUL_A2_P,
    MUL_A2_B2,
    MUL_B2_XN,
    MUL_A2_YN
  } mul_op_e;

  // Register updates the datapath performs
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CAP_IN,
    ACT_CAP_A2,
    ACT_CAP_B2,
    ACT_LOAD,
    ACT_SW_INIT,
    ACT_SW_ADD,
    ACT_SW_FIN,
    ACT_EMIT_PIX,
    ACT_EMIT_DONE,
    ACT_R1_RIGHT,
    ACT_R1_DX,
    ACT_R1_DIAG,
    ACT_R2_END,
    ACT_R2_DOWN,
    ACT_R2_DIAG
  } act_e;

  // Controller to datapath
  typedef struct packed {
    mul_op_e   mul_op;
    act_e      act;
    emit_idx_t emit_idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    restart;
    region_e region;
    logic    dx_lt_dy;
    logic    y_zero;
    logic    dec_neg;
    logic    dec_pos;
    logic    out_free;
  } sts_t;

endpackage

// ----- hw/rtl/mer_if.sv -----
// Valid/ready channel interfaces of the midpoint ellipse rasterizer.
// Depends on mer_pkg for the pixel coordinate width.
`timescale 1ns / 1ps

// Input channel: one word per restart or advance request
interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Output channel: one pixel or one finished marker per word
interface mer_out_if import mer_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [PIX_BITS-1:0] pixel_x;
  logic signed [PIX_BITS-1:0] pixel_y;
  logic                       last;
  logic                       done_res;

  modport source (output valid, output pixel_x, output pixel_y, output last,
                  output done_res, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last,
                input done_res, output ready);
endinterface

// ----- hw/rtl/mer_ctrl.sv -----
// Sequencing state machine of the midpoint ellipse rasterizer.
// Depends on mer_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module mer_ctrl import mer_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e    state_q, state_d;
  emit_idx_t cnt_q, cnt_d;

  // State and pixel counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and pixel counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SQ_B;
      end
      ST_SQ_B: state_d = ST_SQ_C;
      ST_SQ_C: begin
        priority if (sts_i.restart) begin
          state_d = ST_LOAD;
        end else if (sts_i.region == REG_IDLE || sts_i.region == REG_FIN) begin
          state_d = ST_DONE;
        end else if (sts_i.region == REG_ONE && !sts_i.dx_lt_dy) begin
          state_d = ST_SW_T;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_SW_T:   state_d = ST_SW_BT;
      ST_SW_BT:  state_d = ST_SW_U;
      ST_SW_U:   state_d = ST_SW_AU;
      ST_SW_AU:  state_d = ST_SW_AB;
      ST_SW_AB:  state_d = ST_SW_FIN;
      ST_SW_FIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == EMIT_LAST) begin
            state_d = (sts_i.region == REG_ONE) ? ST_R1_UX : ST_R2_DEC;
          end
        end
      end
      ST_R1_UX: state_d = sts_i.dec_neg ? ST_IDLE : ST_R1_UY;
      ST_R1_UY: state_d = ST_IDLE;
      ST_R2_DEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.mul_op    = MUL_RX_SQ;
    cmd_o.act       = ACT_NONE;
    cmd_o.emit_idx  = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.act = ACT_CAP_IN;
      end
      ST_SQ_B: begin
        cmd_o.act    = ACT_CAP_A2;
        cmd_o.mul_op = MUL_RY_SQ;
      end
      ST_SQ_C: begin
        cmd_o.act    = ACT_CAP_B2;
        cmd_o.mul_op = MUL_A2_RY;
      end
      ST_LOAD: cmd_o.act = ACT_LOAD;
      ST_DONE: begin
        if (sts_i.out_free) cmd_o.act = ACT_EMIT_DONE;
      end
      ST_SW_T:  cmd_o.mul_op = MUL_T_SQ;
      ST_SW_BT: cmd_o.mul_op = MUL_B2_P;
      ST_SW_U: begin
        cmd_o.act    = ACT_SW_INIT;
        cmd_o.mul_op = MUL_U_SQ;
      end
      ST_SW_AU: cmd_o.mul_op = MUL_A2_P;
      ST_SW_AB: begin
        cmd_o.act    = ACT_SW_ADD;
        cmd_o.mul_op = MUL_A2_B2;
      end
      ST_SW_FIN: cmd_o.act = ACT_SW_FIN;
      ST_EMIT: begin
        // Prepare the product the following step needs while pixels go out
        cmd_o.mul_op = (sts_i.region == REG_ONE) ? MUL_B2_XN : MUL_A2_YN;
        if (sts_i.out_free) cmd_o.act = ACT_EMIT_PIX;
      end
      ST_R1_UX: begin
        cmd_o.mul_op = MUL_A2_YN;
        cmd_o.act    = sts_i.dec_neg ? ACT_R1_RIGHT : ACT_R1_DX;
      end
      ST_R1_UY: cmd_o.act = ACT_R1_DIAG;
      ST_R2_DEC: begin
        priority if (sts_i.y_zero) begin
          cmd_o.act = ACT_R2_END;
        end else if (sts_i.dec_pos) begin
          cmd_o.act = ACT_R2_DOWN;
        end else begin
          cmd_o.act = ACT_R2_DIAG;
        end
      end
      default: cmd_o.act = ACT_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/mer_dpath.sv -----
// Datapath of the midpoint ellipse rasterizer: configuration registers, arc state,
// the shared multiplier and the output word register. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_dpath import mer_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                       restart_i,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [PIX_BITS-1:0] pixel_x_o,
  output logic signed [PIX_BITS-1:0] pixel_y_o,
  output logic                       last_o,
  output logic                       done_res_o
);

  // Sign extension of a step value to the decision width
  function automatic logic [DEC_BITS-1:0] sx_step(input logic [STEP_BITS-1:0] s);
    return {{(DEC_BITS - STEP_BITS){s[STEP_BITS-1]}}, s};
  endfunction

  logic [COORD_BITS-1:0]       center_x_q, center_y_q;
  logic [RAD_BITS-1:0]         radius_x_q, radius_y_q;
  logic [COORD_BITS-1:0]       cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [STEP_BITS-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [DEC_BITS-1:0]         dec_q, dec_d;
  region_e                     region_q, region_d;
  logic                        restart_q, restart_d;
  logic [SQ_BITS-1:0]          a2_q, a2_d, b2_q, b2_d;
  logic [PROD_BITS-1:0]        prod_q;
  logic [MUL_W-1:0]            opa, opb;
  logic [COORD_BITS-1:0]       x_inc, y_dec, u_abs;
  logic [STEP_BITS-1:0]        prod_dbl, dx_diag, dy_diag;
  logic [DEC_BITS-1:0]         a2_dec, b2_dec, prod_dec;
  logic                        out_valid_q;
  logic signed [PIX_BITS-1:0]  pixel_x_q, pixel_y_q;
  logic                        last_q, done_res_q;
  logic [PIX_BITS-1:0]         cx_pix, cy_pix, x_pix, y_pix;
  logic                        emit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_x_q <= '0;
      radius_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        CFG_RADIUS_X: radius_x_q <= cfg_data_i[RAD_BITS-1:0];
        CFG_RADIUS_Y: radius_y_q <= cfg_data_i[RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Common terms
  assign x_inc    = cur_x_q + COORD_BITS'(1);
  assign y_dec    = cur_y_q - COORD_BITS'(1);
  // y - 1 squared equals one when y is zero, which the unsigned wrap would not give
  assign u_abs    = (cur_y_q == '0) ? COORD_BITS'(1) : y_dec;
  assign prod_dbl = STEP_BITS'({prod_q, 1'b0});
  assign dx_diag  = dx_q + STEP_BITS'({b2_q, 1'b0});
  assign dy_diag  = dy_q - STEP_BITS'({a2_q, 1'b0});
  assign a2_dec   = DEC_BITS'(a2_q);
  assign b2_dec   = DEC_BITS'(b2_q);
  assign prod_dec = DEC_BITS'(prod_q);

  // Shared multiplier operand selection
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul_op)
      MUL_RX_SQ: begin
        opa = MUL_W'(radius_x_q);
        opb = MUL_W'(radius_x_q);
      end
      MUL_RY_SQ: begin
        opa = MUL_W'(radius_y_q);
        opb = MUL_W'(radius_y_q);
      end
      MUL_A2_RY: begin
        opa = MUL_W'(a2_q);
        opb = MUL_W'(radius_y_q);
      end
      MUL_T_SQ: begin
        opa = MUL_W'({cur_x_q, 1'b1});
        opb = MUL_W'({cur_x_q, 1'b1});
      end
      MUL_B2_P: begin
        opa = MUL_W'(b2_q);
        opb = prod_q[MUL_W-1:0];
      end
      MUL_U_SQ: begin
        opa = MUL_W'(u_abs);
        opb = MUL_W'(u_abs);
      end
      MUL_A2_P: begin
        opa = MUL_W'(a2_q);
        opb = prod_q[MUL_W-1:0];
      end
      MUL_A2_B2: begin
        opa = MUL_W'(a2_q);
        opb = MUL_W'(b2_q);
      end
      MUL_B2_XN: begin
        opa = MUL_W'(b2_q);
        opb = MUL_W'(x_inc);
      end
      MUL_A2_YN: begin
        opa = MUL_W'(a2_q);
        opb = MUL_W'(y_dec);
      end
      default: ;
    endcase
  end

  // Product register
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_BITS'(opa) * PROD_BITS'(opb);
  end

  // Arc state updates
  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    dec_d     = dec_q;
    region_d  = region_q;
    restart_d = restart_q;
    a2_d      = a2_q;
    b2_d      = b2_q;
    unique case (cmd_i.act)
      ACT_CAP_IN: restart_d = restart_i;
      ACT_CAP_A2: a2_d = prod_q[SQ_BITS-1:0];
      ACT_CAP_B2: b2_d = prod_q[SQ_BITS-1:0];
      ACT_LOAD: begin
        // Start at the top of the ellipse; product holds a2 * ry
        cur_x_d  = '0;
        cur_y_d  = COORD_BITS'(radius_y_q);
        dx_d     = '0;
        dy_d     = prod_dbl;
        dec_d    = (b2_dec << 2) - (prod_dec << 2) + a2_dec;
        region_d = REG_ONE;
      end
      // Region two start value built over three products
      ACT_SW_INIT: dec_d = prod_dec;
      ACT_SW_ADD:  dec_d = dec_q + (prod_dec << 2);
      ACT_SW_FIN: begin
        dec_d    = dec_q - (prod_dec << 2);
        region_d = REG_TWO;
      end
      ACT_R1_RIGHT: begin
        cur_x_d = x_inc;
        dx_d    = prod_dbl;
        dec_d   = dec_q + ((sx_step(prod_dbl) + b2_dec) << 2);
      end
      ACT_R1_DX: begin
        cur_x_d = x_inc;
        dx_d    = prod_dbl;
      end
      ACT_R1_DIAG: begin
        cur_y_d = y_dec;
        dy_d    = prod_dbl;
        dec_d   = dec_q + ((sx_step(dx_q) - sx_step(prod_dbl) + b2_dec) << 2);
      end
      ACT_R2_END: region_d = REG_FIN;
      ACT_R2_DOWN: begin
        cur_y_d = y_dec;
        dy_d    = prod_dbl;
        dec_d   = dec_q + ((a2_dec - sx_step(prod_dbl)) << 2);
      end
      ACT_R2_DIAG: begin
        cur_x_d = x_inc;
        cur_y_d = y_dec;
        dx_d    = dx_diag;
        dy_d    = dy_diag;
        dec_d   = dec_q + ((sx_step(dx_diag) - sx_step(dy_diag) + a2_dec) << 2);
      end
      default: ;
    endcase
  end

  // Arc state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      dec_q     <= '0;
      region_q  <= REG_IDLE;
      restart_q <= 1'b0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      dec_q     <= dec_d;
      region_q  <= region_d;
      restart_q <= restart_d;
    end
  end

  // Squared radii, refreshed for every word
  always_ff @(posedge clk_i) begin
    a2_q <= a2_d;
    b2_q <= b2_d;
  end

  // Output word register
  assign emit   = (cmd_i.act == ACT_EMIT_PIX) || (cmd_i.act == ACT_EMIT_DONE);
  assign cx_pix = PIX_BITS'(center_x_q);
  assign cy_pix = PIX_BITS'(center_y_q);
  assign x_pix  = PIX_BITS'(cur_x_q);
  assign y_pix  = PIX_BITS'(cur_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Symmetric pixels: bit zero of the index mirrors x, bit one mirrors y
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_EMIT_PIX) begin
      pixel_x_q  <= cmd_i.emit_idx[0] ? cx_pix - x_pix : cx_pix + x_pix;
      pixel_y_q  <= cmd_i.emit_idx[1] ? cy_pix - y_pix : cy_pix + y_pix;
      last_q     <= (cmd_i.emit_idx == EMIT_LAST);
      done_res_q <= 1'b0;
    end else if (cmd_i.act == ACT_EMIT_DONE) begin
      pixel_x_q  <= '0;
      pixel_y_q  <= '0;
      last_q     <= 1'b1;
      done_res_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;
  assign last_o      = last_q;
  assign done_res_o  = done_res_q;

  // Status to the controller
  assign sts_o.restart  = restart_q;
  assign sts_o.region   = region_q;
  assign sts_o.dx_lt_dy = dx_q < dy_q;
  assign sts_o.y_zero   = (cur_y_q == '0);
  assign sts_o.dec_neg  = dec_q[DEC_BITS-1];
  assign sts_o.dec_pos  = !dec_q[DEC_BITS-1] && (dec_q != '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- hw/rtl/midpoint_ellipse_rasterizer_unit.sv -----
// Midpoint ellipse rasterizer: ties the controller to the datapath.
// Depends on mer_pkg, mer_in_if, mer_out_if, mer_ctrl and mer_dpath.
//
// Usage:
//   Write center_x, center_y, radius_x and radius_y on the configuration port
//   (indexes 0 to 3) while the block is idle. Send a word with restart set to
//   load the first point of the arc; it yields no output. Each following word
//   with restart clear yields four output words, the mirrored pixels of the
//   current point, the fourth with last set. Once the arc has ended, or before
//   any restart, such a word yields one output word with done_res and last set.
//   Timing: one input word is worked on at a time. A restart squares the radii
//   and then loads the first point. An advance squares the radii on the shared
//   multiplier, writes the four pixels and then takes the step, with a further
//   state where the step needs a fresh product. The word on which region two
//   begins also passes the states that chain the products of its start value.
//   A finished word squares the radii before its done_res word goes out.
//   A single output register holds the word on offer; while the receiver
//   stalls, the block waits before writing the next pixel.
//   Reset clears the configuration and the arc state; advances then give
//   done_res words until a restart.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit import mer_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  mer_in_if.sink                   in_i,
  mer_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage
  mer_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .restart_i   (in_i.restart),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .pixel_x_o   (out_o.pixel_x),
    .pixel_y_o   (out_o.pixel_y),
    .last_o      (out_o.last),
    .done_res_o  (out_o.done_res)
  );

endmodule

// ----- hw/rtl/mer_checker.sv -----
// Port-level checks of the midpoint ellipse rasterizer, bound to the top level.
// Depends on mer_pkg and midpoint_ellipse_rasterizer_unit.
`timescale 1ns / 1ps

module mer_checker import mer_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [PIX_BITS-1:0] pixel_x_i,
  input logic signed [PIX_BITS-1:0] pixel_y_i,
  input logic                       last_i,
  input logic                       done_res_i
);

  // A stalled word keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_x_i) &&
      $stable(pixel_y_i) && $stable(last_i) && $stable(done_res_i))
    else $error("output word changed while stalled");

  // A finished marker carries no pixel and closes its input word
  a_done_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> last_i && pixel_x_i == '0 && pixel_y_i == '0)
    else $error("done word malformed");

  // One input word at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second input word taken while busy");

  // When a new word may enter, any word still on offer closes the previous one
  a_ready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> last_i)
    else $error("input taken before all output words were written");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pixel_x_i   (out_o.pixel_x),
  .pixel_y_i   (out_o.pixel_y),
  .last_i      (out_o.last),
  .done_res_i  (out_o.done_res)
);
